// ===== hw/rtl/keyboard_scancode_translator_top_defines.svh =====
// Assertion helpers used by the translator RTL
`ifndef KEYBOARD_SCANCODE_TRANSLATOR_TOP_DEFINES_SVH
`define KEYBOARD_SCANCODE_TRANSLATOR_TOP_DEFINES_SVH

// Check a condition at every clock edge outside reset
`define KST_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Check that a trigger is followed by a condition on the next edge
`define KST_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== hw/rtl/kst_pkg.sv =====
package kst_pkg;

  localparam int unsigned KST_CMD_QUEUE_DEPTH = 32;

  // Keyboard command and reply bytes
  localparam logic [7:0] KB_CMD_LED = 8'hED;
  localparam logic [7:0] KB_ACK     = 8'hFA;
  localparam logic [7:0] KB_RESEND  = 8'hFE;

  // Scan codes with a special meaning
  localparam logic [7:0] SC_BKSP       = 8'h0E;
  localparam logic [7:0] SC_ENTER      = 8'h1C;
  localparam logic [7:0] SC_TAB        = 8'h0F;
  localparam logic [7:0] SC_KEY_C      = 8'h2E;
  localparam logic [7:0] SC_KEY_T      = 8'h14;
  localparam logic [7:0] SC_LSHIFT     = 8'h2A;
  localparam logic [7:0] SC_RSHIFT     = 8'h36;
  localparam logic [7:0] SC_LSHIFT_BRK = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_BRK = 8'hB6;
  localparam logic [7:0] SC_LCTRL      = 8'h1D;
  localparam logic [7:0] SC_LCTRL_BRK  = 8'h9D;
  localparam logic [7:0] SC_LALT       = 8'h38;
  localparam logic [7:0] SC_LALT_BRK   = 8'hB8;
  localparam logic [7:0] SC_CAPS       = 8'h3A;
  localparam logic [7:0] SC_NUM        = 8'h45;
  localparam logic [7:0] SC_SCROLL     = 8'h46;

  localparam logic [7:0] ASCII_BS = 8'h08;
  localparam logic [7:0] ASCII_LF = 8'h0A;

  // Hotkey event codes
  localparam logic [7:0] HOT_TAB    = 8'd0;
  localparam logic [7:0] HOT_BREAK  = 8'd1;
  localparam logic [7:0] HOT_NEWCON = 8'd2;

  // LED bits
  localparam logic [2:0] LED_CAPS   = 3'b100;
  localparam logic [2:0] LED_NUM    = 3'b010;
  localparam logic [2:0] LED_SCROLL = 3'b001;

  typedef enum logic [1:0] {
    KIND_CHAR   = 2'd0,
    KIND_CMD    = 2'd1,
    KIND_HOTKEY = 2'd2
  } kind_e;

  // Work handed from the classifier to the output side
  typedef struct packed {
    logic       has_first;
    kind_e      first_kind;
    logic [7:0] first_value;
    logic       has_send;
    logic [7:0] send_value;
  } job_t;

  // Unshifted key table
  function automatic logic [7:0] plain_map(input logic [6:0] code);
    logic [7:0] c;
    c = 8'h00;
    unique case (code)
      7'h02: c = 8'h31; 7'h03: c = 8'h32; 7'h04: c = 8'h33; 7'h05: c = 8'h34;
      7'h06: c = 8'h35; 7'h07: c = 8'h36; 7'h08: c = 8'h37; 7'h09: c = 8'h38;
      7'h0A: c = 8'h39; 7'h0B: c = 8'h30; 7'h0C: c = 8'h2D; 7'h0D: c = 8'h3D;
      7'h10: c = 8'h51; 7'h11: c = 8'h57; 7'h12: c = 8'h45; 7'h13: c = 8'h52;
      7'h14: c = 8'h54; 7'h15: c = 8'h59; 7'h16: c = 8'h55; 7'h17: c = 8'h49;
      7'h18: c = 8'h4F; 7'h19: c = 8'h50; 7'h1A: c = 8'h5B; 7'h1B: c = 8'h5D;
      7'h1E: c = 8'h41; 7'h1F: c = 8'h53;
      7'h20: c = 8'h44; 7'h21: c = 8'h46; 7'h22: c = 8'h47; 7'h23: c = 8'h48;
      7'h24: c = 8'h4A; 7'h25: c = 8'h4B; 7'h26: c = 8'h4C; 7'h27: c = 8'h3B;
      7'h28: c = 8'h27; 7'h29: c = 8'h60; 7'h2B: c = 8'h5C; 7'h2C: c = 8'h5A;
      7'h2D: c = 8'h58; 7'h2E: c = 8'h43; 7'h2F: c = 8'h56;
      7'h30: c = 8'h42; 7'h31: c = 8'h4E; 7'h32: c = 8'h4D; 7'h33: c = 8'h2C;
      7'h34: c = 8'h2E; 7'h35: c = 8'h2F; 7'h37: c = 8'h2A; 7'h39: c = 8'h20;
      7'h47: c = 8'h37; 7'h48: c = 8'h38; 7'h49: c = 8'h39; 7'h4A: c = 8'h2D;
      7'h4B: c = 8'h34; 7'h4C: c = 8'h35; 7'h4D: c = 8'h36; 7'h4E: c = 8'h2B;
      7'h4F: c = 8'h31;
      7'h50: c = 8'h32; 7'h51: c = 8'h33; 7'h52: c = 8'h30; 7'h53: c = 8'h2E;
      7'h73: c = 8'h5C; 7'h7D: c = 8'h5C;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Shifted key table: differs from the plain one on the number row and symbol keys only
  function automatic logic [7:0] shift_map(input logic [6:0] code);
    logic [7:0] c;
    c = plain_map(code);
    unique case (code)
      7'h02: c = 8'h21; 7'h03: c = 8'h40; 7'h04: c = 8'h23; 7'h05: c = 8'h24;
      7'h06: c = 8'h25; 7'h07: c = 8'h5E; 7'h08: c = 8'h26; 7'h09: c = 8'h2A;
      7'h0A: c = 8'h28; 7'h0B: c = 8'h29; 7'h0C: c = 8'h5F; 7'h0D: c = 8'h2B;
      7'h1A: c = 8'h7B; 7'h1B: c = 8'h7D;
      7'h27: c = 8'h3A; 7'h28: c = 8'h22; 7'h29: c = 8'h7E; 7'h2B: c = 8'h7C;
      7'h33: c = 8'h3C; 7'h34: c = 8'h3E; 7'h35: c = 8'h3F;
      7'h73: c = 8'h5F; 7'h7D: c = 8'h7C;
      default: ;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/kst_ram.sv =====
module kst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port, and registered read returning the old contents
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/kst_front.sv =====
`include "keyboard_scancode_translator_top_defines.svh"

module kst_front import kst_pkg::*; #(
  parameter int unsigned CMD_QUEUE_DEPTH = KST_CMD_QUEUE_DEPTH,
  localparam int unsigned PTR_W = $clog2(CMD_QUEUE_DEPTH),
  localparam int unsigned CNT_W = $clog2(CMD_QUEUE_DEPTH + 1)
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_wdata_i,
  input  logic       in_valid_i,
  input  logic [7:0] scancode_i,
  output logic       in_ready_o,
  output logic       job_valid_o,
  output job_t       job_o,
  input  logic       job_ready_i
);

  localparam logic [1:0] ST_INIT0 = 2'd0;
  localparam logic [1:0] ST_INIT1 = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;
  localparam logic [1:0] ST_LED   = 2'd3;

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CMD_QUEUE_DEPTH - 1);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  logic [1:0]       state_q, state_d;
  logic [1:0]       shift_q, shift_d;
  logic             ctrl_q, ctrl_d;
  logic             alt_q, alt_d;
  logic [2:0]       leds_q, leds_d;
  logic             await_q, await_d;
  logic [7:0]       pending_q, pending_d;
  logic [PTR_W-1:0] head_q, head_d;
  logic [PTR_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [2:0]       led_val_q, led_val_d;

  logic             wr_en;
  logic [PTR_W-1:0] wr_addr;
  logic [7:0]       wr_data;
  logic             wr_en_q;
  logic [PTR_W-1:0] wr_addr_q;
  logic [7:0]       wr_data_q;
  logic [7:0]       rd_data;

  logic       accept;
  logic       shifted;
  logic [7:0] c_raw;
  logic [7:0] c_char;
  logic       char_ok;
  logic       has_first;
  kind_e      first_kind;
  logic [7:0] first_value;
  logic [2:0] toggle_mask;
  logic       toggle;
  logic [2:0] leds_new;
  logic       await_mid;
  logic       push0, push1;
  logic       send;
  logic [7:0] head_byte;

  assign in_ready_o = (state_q == ST_RUN) && job_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Look up the character and fold in caps lock
  always_comb begin
    shifted = (shift_q != 2'b00);
    c_raw   = shifted ? shift_map(scancode_i[6:0]) : plain_map(scancode_i[6:0]);
    c_char  = c_raw;
    if ((c_raw >= 8'h41) && (c_raw <= 8'h5A) && (leds_q[2] == shifted)) begin
      c_char = c_raw + 8'h20;
    end
    char_ok = !scancode_i[7] && (c_char != 8'h00) && !ctrl_q && !alt_q;
  end

  // Classify the byte: first result, modifier and LED changes, ack and resend
  always_comb begin
    has_first   = char_ok;
    first_kind  = KIND_CHAR;
    first_value = c_char;
    toggle_mask = 3'b000;
    shift_d     = shift_q;
    ctrl_d      = ctrl_q;
    alt_d       = alt_q;
    await_mid   = await_q;
    unique case (scancode_i)
      SC_BKSP: begin
        has_first   = 1'b1;
        first_value = ASCII_BS;
      end
      SC_ENTER: begin
        has_first   = 1'b1;
        first_value = ASCII_LF;
      end
      SC_TAB: begin
        has_first   = 1'b1;
        first_kind  = KIND_HOTKEY;
        first_value = HOT_TAB;
      end
      SC_KEY_C: begin
        if (ctrl_q) begin
          has_first   = 1'b1;
          first_kind  = KIND_HOTKEY;
          first_value = HOT_BREAK;
        end
      end
      SC_KEY_T: begin
        if (ctrl_q) begin
          has_first   = 1'b1;
          first_kind  = KIND_HOTKEY;
          first_value = HOT_NEWCON;
        end
      end
      SC_LSHIFT:     shift_d = shift_q | 2'b01;
      SC_RSHIFT:     shift_d = shift_q | 2'b10;
      SC_LSHIFT_BRK: shift_d = shift_q & 2'b10;
      SC_RSHIFT_BRK: shift_d = shift_q & 2'b01;
      SC_LCTRL:      ctrl_d = 1'b1;
      SC_LCTRL_BRK:  ctrl_d = 1'b0;
      SC_LALT:       alt_d = 1'b1;
      SC_LALT_BRK:   alt_d = 1'b0;
      SC_CAPS:       toggle_mask = LED_CAPS;
      SC_NUM:        toggle_mask = LED_NUM;
      SC_SCROLL:     toggle_mask = LED_SCROLL;
      KB_ACK:        await_mid = 1'b0;
      KB_RESEND: begin
        if (await_q) begin
          has_first   = 1'b1;
          first_kind  = KIND_CMD;
          first_value = pending_q;
        end
      end
      default: ;
    endcase
  end

  // Queue pushes, send decision and the byte at the queue head
  always_comb begin
    toggle    = (toggle_mask != 3'b000);
    leds_new  = leds_q ^ toggle_mask;
    push0     = toggle && (count_q < CNT_W'(CMD_QUEUE_DEPTH));
    push1     = toggle && (count_q < CNT_W'(CMD_QUEUE_DEPTH - 1));
    send      = !await_mid && ((count_q != '0) || toggle);
    if (count_q == '0) begin
      head_byte = KB_CMD_LED;
    end else if (wr_en_q && (wr_addr_q == head_q)) begin
      head_byte = wr_data_q;
    end else begin
      head_byte = rd_data;
    end
  end

  // Next state of the command path
  always_comb begin
    state_d   = state_q;
    leds_d    = leds_q;
    await_d   = await_q;
    pending_d = pending_q;
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    led_val_d = led_val_q;
    wr_en     = 1'b0;
    wr_addr   = tail_q;
    wr_data   = KB_CMD_LED;
    if (cfg_we_i) begin
      // Restart the command path with the LED command queued
      state_d   = ST_INIT0;
      leds_d    = cfg_wdata_i;
      await_d   = 1'b0;
      pending_d = 8'h00;
      head_d    = '0;
      tail_d    = PTR_W'(2);
      count_d   = CNT_W'(2);
    end else begin
      unique case (state_q)
        ST_INIT0: begin
          wr_en   = 1'b1;
          wr_addr = '0;
          wr_data = KB_CMD_LED;
          state_d = ST_INIT1;
        end
        ST_INIT1: begin
          wr_en   = 1'b1;
          wr_addr = PTR_W'(1);
          wr_data = {5'b00000, leds_q};
          state_d = ST_RUN;
        end
        ST_RUN: begin
          if (accept) begin
            leds_d = leds_new;
            if (push0) begin
              wr_en  = 1'b1;
              tail_d = ptr_inc(tail_q);
            end
            if (push1) begin
              led_val_d = leds_new;
              state_d   = ST_LED;
            end
            if (send) begin
              head_d    = ptr_inc(head_q);
              pending_d = head_byte;
              await_d   = 1'b1;
            end else begin
              await_d = await_mid;
            end
            count_d = count_q + CNT_W'(push0) + CNT_W'(push1) - CNT_W'(send);
          end
        end
        ST_LED: begin
          // Write the LED byte that follows the command
          wr_en   = 1'b1;
          wr_data = {5'b00000, led_val_q};
          tail_d  = ptr_inc(tail_q);
          state_d = ST_RUN;
        end
        default: state_d = ST_INIT0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_INIT0;
      shift_q   <= 2'b00;
      ctrl_q    <= 1'b0;
      alt_q     <= 1'b0;
      leds_q    <= 3'b000;
      await_q   <= 1'b0;
      pending_q <= 8'h00;
      head_q    <= '0;
      tail_q    <= PTR_W'(2);
      count_q   <= CNT_W'(2);
      wr_en_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      leds_q    <= leds_d;
      await_q   <= await_d;
      pending_q <= pending_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      count_q   <= count_d;
      wr_en_q   <= wr_en;
      if (accept) begin
        shift_q <= shift_d;
        ctrl_q  <= ctrl_d;
        alt_q   <= alt_d;
      end
    end
  end

  // Hold the last write for bypass onto the head read, and the LED byte
  always_ff @(posedge clk_i) begin
    wr_addr_q <= wr_addr;
    wr_data_q <= wr_data;
    led_val_q <= led_val_d;
  end

  kst_ram #(
    .WIDTH (8),
    .DEPTH (CMD_QUEUE_DEPTH)
  ) u_cmd_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (head_d),
    .rdata_o (rd_data)
  );

  assign job_valid_o       = accept && (has_first || send);
  assign job_o.has_first   = has_first;
  assign job_o.first_kind  = first_kind;
  assign job_o.first_value = first_value;
  assign job_o.has_send    = send;
  assign job_o.send_value  = head_byte;

  `KST_ASSERT(a_count_bound, count_q <= CNT_W'(CMD_QUEUE_DEPTH), "command queue overfilled")
  `KST_ASSERT_NEXT(a_send_awaits, accept && send && !cfg_we_i, await_q, "send left no ack wait")
  `KST_ASSERT(a_empty_ptrs, !((state_q == ST_RUN) && (count_q == '0)) || (head_q == tail_q),
              "empty queue with unequal pointers")
  `KST_ASSERT_NEXT(a_led_push, accept && push1 && !cfg_we_i, state_q == ST_LED,
                   "second LED push not scheduled")

endmodule

// ===== hw/rtl/kst_back.sv =====
module kst_back import kst_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       job_valid_i,
  input  job_t       job_i,
  output logic       job_ready_o,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] kind_o,
  output logic [7:0] value_o,
  output logic       last_o
);

  job_t       jobs_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       sub_q;
  job_t       head;
  logic       show_send;
  logic       enq, deq, take;

  assign job_ready_o = (cnt_q != 2'd2);
  assign enq         = job_valid_i && job_ready_o;
  assign empty       = (cnt_q == 2'd0);
  assign head        = jobs_q[rp_q];

  // Present the first result of the oldest job, then its command byte
  assign show_send = sub_q || !head.has_first;
  assign kind_o    = show_send ? KIND_CMD : head.first_kind;
  assign value_o   = show_send ? head.send_value : head.first_value;
  assign last_o    = show_send || !head.has_send;

  assign take = pop && !empty;
  assign deq  = take && last_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
      sub_q <= 1'b0;
    end else begin
      if (enq) begin
        wp_q <= ~wp_q;
      end
      if (deq) begin
        rp_q <= ~rp_q;
      end
      if (take) begin
        sub_q <= !last_o;
      end
      cnt_q <= cnt_q + {1'b0, enq} - {1'b0, deq};
    end
  end

  // Store the job payload
  always_ff @(posedge clk_i) begin
    if (enq) begin
      jobs_q[wp_q] <= job_i;
    end
  end

endmodule

// ===== hw/rtl/keyboard_scancode_translator_top.sv =====
// The results of an accepted byte are held in a two-entry job queue before the result ports.
// One byte is accepted per cycle while full is low; a lock key that queues two command
// bytes holds full high for the second write through the single command RAM port.
// Results leave one per cycle while pop is high; a byte with two results is popped twice.
// Reset (and each cfg_we_i write): the ST_INIT0 and ST_INIT1 states load 0xED and the LED
// byte into the command RAM while full is held high.
module keyboard_scancode_translator_top import kst_pkg::*; #(
  parameter int unsigned CMD_QUEUE_DEPTH = KST_CMD_QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_wdata_i,
  input  logic       push,
  output logic       full,
  input  logic [7:0] scancode_i,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] kind_o,
  output logic [7:0] value_o,
  output logic       last_o
);

  logic in_ready;
  logic job_valid;
  logic job_ready;
  job_t job;

  assign full = !in_ready;

  kst_front #(
    .CMD_QUEUE_DEPTH (CMD_QUEUE_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (push),
    .scancode_i  (scancode_i),
    .in_ready_o  (in_ready),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_ready_i (job_ready)
  );

  kst_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_ready_o (job_ready),
    .empty       (empty),
    .pop         (pop),
    .kind_o      (kind_o),
    .value_o     (value_o),
    .last_o      (last_o)
  );

endmodule
